// ----- sv/amp_pkg.sv -----
// Shared constants and helper functions for the angular-map pixel address core.
package amp_pkg;

    // Field widths.
    localparam int DIR_W   = 16;
    localparam int DIM_W   = 13;
    localparam int THR_W   = 15;
    localparam int PIX_W   = 12;
    localparam int OFS_W   = 26;
    localparam int CFG_IDX_W = 2;

    // Index of the last pipeline stage before the output register.
    localparam int PIPE_LAST = 38;

    // Largest image side in pixels.
    localparam logic [DIM_W-1:0] MAX_IMAGE_DIM = 13'd4096;

    // Unit length in Q1.14.
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // Arc cosine polynomial coefficients over pi, Q0.24.
    localparam logic [23:0] ACOS_C0 = 24'd8388247;
    localparam logic [20:0] ACOS_C1 = 21'd1132766;
    localparam logic [18:0] ACOS_C2 = 19'd396580;
    localparam logic [16:0] ACOS_C3 = 17'd100021;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_THRESHOLD = 2'd2;

    // Saturate a signed direction component to [-1.0, 1.0].
    function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [DIR_W-1:0] v);
        logic signed [DIR_W-1:0] r;
        r = v;
        if (v > 16'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (v < -16'sd16384)
        begin
            r = -16'sd16384;
        end
        return r;
    endfunction

    // Clamp an image side to [1, MAX_IMAGE_DIM].
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = 13'd1;
        end
        else if (v > MAX_IMAGE_DIM)
        begin
            r = MAX_IMAGE_DIM;
        end
        return r;
    endfunction

endpackage

// ----- sv/amp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, 17 stages.
module amp_isqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] v,
    output logic [16:0] root
);

    logic [34:0] rem_reg  [0:16];
    logic [16:0] root_reg [0:16];

    genvar g;
    generate
        for (g = 0; g < 17; g++)
        begin : g_stage
            localparam int K = 16 - g;
            logic [34:0] rin;
            logic [16:0] qin;
            logic [34:0] trial;

            if (g == 0)
            begin : g_first
                assign rin = {2'b00, v};
                assign qin = '0;
            end
            else
            begin : g_rest
                assign rin = rem_reg[g-1];
                assign qin = root_reg[g-1];
            end

            // Trial subtraction of 2*r*2^k + 2^2k.
            assign trial = ({18'd0, qin} << (K + 1)) | (35'd1 << (2 * K));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rin >= trial)
                    begin
                        rem_reg[g]  <= rin - trial;
                        root_reg[g] <= qin | (17'd1 << K);
                    end
                    else
                    begin
                        rem_reg[g]  <= rin;
                        root_reg[g] <= qin;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[16];

endmodule

// ----- sv/amp_div.sv -----
// Pipelined restoring divider: num / (den << 17), 13 quotient bits, one per stage.
module amp_div
(
    input  logic        clk,
    input  logic        en,
    input  logic [44:0] num,
    input  logic [14:0] den,
    output logic [12:0] quo
);

    logic [45:0] rem_reg [0:12];
    logic [14:0] den_reg [0:12];
    logic [12:0] quo_reg [0:12];

    genvar g;
    generate
        for (g = 0; g < 13; g++)
        begin : g_stage
            localparam int I = 12 - g;
            logic [45:0] rin;
            logic [14:0] din;
            logic [12:0] qin;
            logic [45:0] trial;

            if (g == 0)
            begin : g_first
                assign rin = {1'b0, num};
                assign din = den;
                assign qin = '0;
            end
            else
            begin : g_rest
                assign rin = rem_reg[g-1];
                assign din = den_reg[g-1];
                assign qin = quo_reg[g-1];
            end

            // Divisor aligned to this quotient bit.
            assign trial = {31'd0, din} << (17 + I);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g] <= din;
                    if (rin >= trial)
                    begin
                        rem_reg[g] <= rin - trial;
                        quo_reg[g] <= qin | (13'd1 << I);
                    end
                    else
                    begin
                        rem_reg[g] <= rin;
                        quo_reg[g] <= qin;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[12];

endmodule

// ----- sv/angular_map_pixel_address_core.sv -----
// Angular-map light probe pixel address core: direction in, pixel and RGB byte offset out.
//
// The core takes one Q1.14 direction per clock while s_tready is high and returns one result
// per direction, in order. Its path runs through two 17-stage square root pipelines (planar
// length and the arc cosine correction), two 13-stage quotient pipelines for column and row,
// and multiply stages around them. A two-entry output buffer lets the core keep taking
// requests after the consumer stalls until a result lands in the skid entry; the whole
// pipeline then holds until that entry drains. Configuration registers must be written
// only while no request is in flight.
module angular_map_pixel_address_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // Direction requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    // Pixel results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // pixel_col[11:0], pixel_row[23:12], byte_offset[49:24]
);

    // Configuration registers.
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [14:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1024;
            height_reg <= 13'd1024;
            thr_reg    <= 15'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amp_pkg::CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[12:0];
                amp_pkg::CFG_IMAGE_HEIGHT:   height_reg <= cfg_data[12:0];
                amp_pkg::CFG_AXIS_THRESHOLD: thr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [12:0] w;
    logic [12:0] h;
    assign w = amp_pkg::clamp_dim(width_reg);
    assign h = amp_pkg::clamp_dim(height_reg);

    // Pipeline advance.
    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic vld_reg [0:amp_pkg::PIPE_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n <= amp_pkg::PIPE_LAST; n++)
            begin
                vld_reg[n] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int n = 1; n <= amp_pkg::PIPE_LAST; n++)
            begin
                vld_reg[n] <= vld_reg[n-1];
            end
        end
    end

    // Stage 0: saturated components.
    logic signed [15:0] x_reg [0:20];
    logic signed [15:0] y_reg [0:20];
    logic signed [15:0] z0_reg;

    // Stages 1..3: squared length and arc cosine operands.
    logic [30:0] d2_reg;
    logic [32:0] rad_reg;
    logic [14:0] t_reg [1:2];
    logic        zneg_reg [1:19];
    logic [18:0] p1_reg;
    logic [20:0] q2_reg;
    logic [23:0] p_reg [3:18];

    logic [14:0] ax0, ay0, t0;
    assign ax0 = x_reg[0][15] ? 15'(-x_reg[0]) : x_reg[0][14:0];
    assign ay0 = y_reg[0][15] ? 15'(-y_reg[0]) : y_reg[0][14:0];
    assign t0  = z0_reg[15] ? 15'(-z0_reg) : z0_reg[14:0];

    logic [31:0] c3t;
    logic [33:0] p1t;
    logic [35:0] q2t;
    assign c3t = 32'(amp_pkg::ACOS_C3) * 32'(t0);
    assign p1t = 34'(p1_reg) * 34'(t_reg[1]);
    assign q2t = 36'(q2_reg) * 36'(t_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= amp_pkg::sat_dir(s_tdata[15:0]);
            y_reg[0] <= amp_pkg::sat_dir(s_tdata[31:16]);
            z0_reg   <= amp_pkg::sat_dir(s_tdata[47:32]);
            for (int n = 1; n <= 20; n++)
            begin
                x_reg[n] <= x_reg[n-1];
                y_reg[n] <= y_reg[n-1];
            end

            d2_reg      <= 31'(30'(ax0) * 30'(ax0)) + 31'(30'(ay0) * 30'(ay0));
            // (1 - |z|) scaled by 2^18.
            rad_reg     <= {amp_pkg::ONE_Q14 - t0, 18'd0};
            t_reg[1]    <= t0;
            zneg_reg[1] <= z0_reg[15];
            // Polynomial in |z|, Horner form, every coefficient sign known.
            p1_reg      <= amp_pkg::ACOS_C2 - 19'(c3t >> 14);

            t_reg[2]    <= t_reg[1];
            q2_reg      <= amp_pkg::ACOS_C1 - 21'(p1t >> 14);

            p_reg[3]    <= amp_pkg::ACOS_C0 - 24'(q2t >> 14);
            for (int n = 4; n <= 18; n++)
            begin
                p_reg[n] <= p_reg[n-1];
            end
            for (int n = 2; n <= 19; n++)
            begin
                zneg_reg[n] <= zneg_reg[n-1];
            end
        end
    end

    // Stages 2..18: planar length and sqrt(1 - |z|).
    logic [16:0] d_root;
    logic [16:0] s_root;

    amp_isqrt u_len_sqrt
    (
        .clk  (clk),
        .en   (en),
        .v    ({2'b00, d2_reg}),
        .root (d_root)
    );

    amp_isqrt u_acos_sqrt
    (
        .clk  (clk),
        .en   (en),
        .v    (rad_reg),
        .root (s_root)
    );

    // Stages 19..23: angle, numerators and scaled numerators.
    logic [39:0]        prod_reg;
    logic [14:0]        d_reg [19:23];
    logic               near_reg [19:36];
    logic [16:0]        theta_reg;
    logic signed [33:0] xt_reg;
    logic signed [33:0] yt_reg;
    logic [31:0]        nx_reg;
    logic [31:0]        ny_reg;
    logic [44:0]        nxw_reg;
    logic [44:0]        nyh_reg;

    logic [16:0] a20;
    assign a20 = 17'((prod_reg + 40'd8388608) >> 24);

    logic signed [34:0] base22, nxs22, nys22;
    assign base22 = {4'd0, d_reg[21], 16'd0};
    assign nxs22  = base22 + 35'(xt_reg);
    assign nys22  = base22 - 35'(yt_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= 40'(p_reg[18]) * 40'(s_root);
            d_reg[19]    <= d_root[14:0];
            near_reg[19] <= d_root <= {2'b00, thr_reg};

            theta_reg <= zneg_reg[19] ? 17'(18'd65536 - 18'(a20)) : a20;

            xt_reg <= 34'(x_reg[20]) * $signed({17'd0, theta_reg});
            yt_reg <= 34'(y_reg[20]) * $signed({17'd0, theta_reg});

            nx_reg <= nxs22[34] ? 32'd0 : nxs22[31:0];
            ny_reg <= nys22[34] ? 32'd0 : nys22[31:0];

            nxw_reg <= 45'(nx_reg) * 45'(w);
            nyh_reg <= 45'(ny_reg) * 45'(h);

            for (int n = 20; n <= 23; n++)
            begin
                d_reg[n] <= d_reg[n-1];
            end
            for (int n = 20; n <= 36; n++)
            begin
                near_reg[n] <= near_reg[n-1];
            end
        end
    end

    // Stages 24..36: column and row quotients.
    logic [12:0] qx;
    logic [12:0] qy;

    amp_div u_col_div
    (
        .clk (clk),
        .en  (en),
        .num (nxw_reg),
        .den (d_reg[23]),
        .quo (qx)
    );

    amp_div u_row_div
    (
        .clk (clk),
        .en  (en),
        .num (nyh_reg),
        .den (d_reg[23]),
        .quo (qy)
    );

    // Stages 37..38: edge saturation and linear pixel index.
    logic [11:0] col_reg [37:38];
    logic [11:0] row_reg;
    logic [11:0] row_reg_d;
    logic [23:0] lin_reg;

    logic [12:0] wm1, hm1, col37, row37;
    assign wm1   = w - 13'd1;
    assign hm1   = h - 13'd1;
    assign col37 = near_reg[36] ? (w >> 1) : ((qx > wm1) ? wm1 : qx);
    assign row37 = near_reg[36] ? (h >> 1) : ((qy > hm1) ? hm1 : qy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg[37] <= col37[11:0];
            row_reg     <= row37[11:0];
            col_reg[38] <= col_reg[37];
            row_reg_d   <= row_reg;
            lin_reg     <= 24'(row_reg) * 24'(w) + 24'(col_reg[37]);
        end
    end

    // Output register and skid entry.
    logic [49:0] res_next;
    logic [49:0] out_reg;
    logic [49:0] skid_reg;
    logic        out_valid_reg;
    logic        out_fire;
    logic        incoming;

    assign res_next = {26'({2'b00, lin_reg} + {1'b0, lin_reg, 1'b0}),
                       row_reg_d,
                       col_reg[38]};

    assign out_fire = out_valid_reg && m_tready;
    assign incoming = en && vld_reg[amp_pkg::PIPE_LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule
